/* sv/nlss_pkg.sv */
// nlss_pkg: shared types, letter codes and the letter decoder of the
// norwegian light suffix stemmer. No dependencies.

package nlss_pkg;

  localparam int WIN           = 7;
  localparam int CHAR_MAX_BITS = 21;

  localparam logic [0:0] REG_USE_BOKMAAL = 1'b0;
  localparam logic [0:0] REG_USE_NYNORSK = 1'b1;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_K = 8'h6B;
  localparam logic [7:0] CH_L = 8'h6C;
  localparam logic [7:0] CH_M = 8'h6D;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_O = 8'h6F;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_T = 8'h74;

  typedef enum logic [3:0] {
    LTR_A, LTR_D, LTR_E, LTR_H, LTR_I, LTR_K, LTR_L,
    LTR_M, LTR_N, LTR_O, LTR_R, LTR_S, LTR_T
  } ltr_e_t;

  localparam int LTR_NUM = 13;

  typedef logic [LTR_NUM-1:0] ltr_vec_t;
  typedef ltr_vec_t [WIN-1:0] win_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

  function automatic ltr_vec_t ltr_decode(input logic [CHAR_MAX_BITS-1:0] c);
    ltr_vec_t f;
    f = '0;
    f[LTR_A] = (c == CHAR_MAX_BITS'(CH_A));
    f[LTR_D] = (c == CHAR_MAX_BITS'(CH_D));
    f[LTR_E] = (c == CHAR_MAX_BITS'(CH_E));
    f[LTR_H] = (c == CHAR_MAX_BITS'(CH_H));
    f[LTR_I] = (c == CHAR_MAX_BITS'(CH_I));
    f[LTR_K] = (c == CHAR_MAX_BITS'(CH_K));
    f[LTR_L] = (c == CHAR_MAX_BITS'(CH_L));
    f[LTR_M] = (c == CHAR_MAX_BITS'(CH_M));
    f[LTR_N] = (c == CHAR_MAX_BITS'(CH_N));
    f[LTR_O] = (c == CHAR_MAX_BITS'(CH_O));
    f[LTR_R] = (c == CHAR_MAX_BITS'(CH_R));
    f[LTR_S] = (c == CHAR_MAX_BITS'(CH_S));
    f[LTR_T] = (c == CHAR_MAX_BITS'(CH_T));
    return f;
  endfunction

endpackage

/* sv/nlss_cell.sv */
// nlss_cell: one character slot of the tail window; shifts to its neighbour
// on each transfer, clears on a tlast transfer, and decodes its input char.
// Depends on nlss_pkg.

module nlss_cell #(
  parameter int CHAR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nlss_pkg::cell_ctl_t   ctl,
  input  logic [CHAR_BITS-1:0]  din,
  output logic [CHAR_BITS-1:0]  dout,
  output nlss_pkg::ltr_vec_t    flags
);

  logic [CHAR_BITS-1:0] chr_r;
  logic [CHAR_BITS-1:0] chr_nxt;

  always_comb begin
    chr_nxt = chr_r;
    if (ctl.shift) begin
      chr_nxt = ctl.clr ? '0 : din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_r <= '0;
    end else begin
      chr_r <= chr_nxt;
    end
  end

  assign dout  = chr_r;
  assign flags = nlss_pkg::ltr_decode(nlss_pkg::CHAR_MAX_BITS'(din));

endmodule

/* sv/nlss_rules.sv */
// nlss_rules: suffix rule priority logic over the decoded tail window.
// Depends on nlss_pkg.

module nlss_rules #(
  parameter int LEN_W = 8
) (
  input  nlss_pkg::win_t     win,
  input  logic [LEN_W-1:0]   len,
  input  logic               bm,
  input  logic               nn,
  output logic [7:0]         stem
);

  localparam int XW = (LEN_W > 8) ? LEN_W : 8;

  typedef nlss_pkg::ltr_vec_t [5:0] sfx_win_t;

  function automatic logic e2(input sfx_win_t w, input nlss_pkg::ltr_e_t a, b);
    return w[1][a] & w[0][b];
  endfunction

  function automatic logic e3(input sfx_win_t w, input nlss_pkg::ltr_e_t a, b, c);
    return w[2][a] & e2(w, b, c);
  endfunction

  function automatic logic e4(input sfx_win_t w, input nlss_pkg::ltr_e_t a, b, c, d);
    return w[3][a] & e3(w, b, c, d);
  endfunction

  function automatic logic e5(input sfx_win_t w,
                              input nlss_pkg::ltr_e_t a, b, c, d, e);
    return w[4][a] & e4(w, b, c, d, e);
  endfunction

  function automatic logic e6(input sfx_win_t w,
                              input nlss_pkg::ltr_e_t a, b, c, d, e, f);
    return w[5][a] & e5(w, b, c, d, e, f);
  endfunction

  logic             poss;
  logic [LEN_W-1:0] len_a;
  sfx_win_t         sw;
  logic [2:0]       cut;
  logic [LEN_W-1:0] res;
  logic [XW-1:0]    res_x;

  always_comb begin
    poss  = (len > LEN_W'(4)) && win[0][nlss_pkg::LTR_S];
    len_a = len - LEN_W'(poss);
    for (int i = 0; i < 6; i++) begin
      sw[i] = poss ? win[i+1] : win[i];
    end

    priority if (len_a > LEN_W'(7) &&
                 ((bm && e5(sw, nlss_pkg::LTR_H, nlss_pkg::LTR_E, nlss_pkg::LTR_T,
                            nlss_pkg::LTR_E, nlss_pkg::LTR_R)) ||
                  (bm && e5(sw, nlss_pkg::LTR_H, nlss_pkg::LTR_E, nlss_pkg::LTR_T,
                            nlss_pkg::LTR_E, nlss_pkg::LTR_N)) ||
                  (nn && e5(sw, nlss_pkg::LTR_H, nlss_pkg::LTR_E, nlss_pkg::LTR_I,
                            nlss_pkg::LTR_T, nlss_pkg::LTR_A)))) begin
      cut = 3'd5;
    end else if (len_a > LEN_W'(8) && nn &&
                 (e6(sw, nlss_pkg::LTR_H, nlss_pkg::LTR_E, nlss_pkg::LTR_I,
                     nlss_pkg::LTR_T, nlss_pkg::LTR_E, nlss_pkg::LTR_R) ||
                  e6(sw, nlss_pkg::LTR_L, nlss_pkg::LTR_E, nlss_pkg::LTR_I,
                     nlss_pkg::LTR_K, nlss_pkg::LTR_E, nlss_pkg::LTR_N) ||
                  e6(sw, nlss_pkg::LTR_L, nlss_pkg::LTR_E, nlss_pkg::LTR_I,
                     nlss_pkg::LTR_K, nlss_pkg::LTR_A, nlss_pkg::LTR_R))) begin
      cut = 3'd6;
    end else if (len_a > LEN_W'(5) &&
                 (e3(sw, nlss_pkg::LTR_D, nlss_pkg::LTR_O, nlss_pkg::LTR_M) ||
                  (bm && e3(sw, nlss_pkg::LTR_H, nlss_pkg::LTR_E, nlss_pkg::LTR_T)))) begin
      cut = 3'd3;
    end else if (len_a > LEN_W'(6) && nn &&
                 (e4(sw, nlss_pkg::LTR_H, nlss_pkg::LTR_E, nlss_pkg::LTR_I,
                     nlss_pkg::LTR_T) ||
                  e4(sw, nlss_pkg::LTR_S, nlss_pkg::LTR_E, nlss_pkg::LTR_M,
                     nlss_pkg::LTR_D) ||
                  e4(sw, nlss_pkg::LTR_L, nlss_pkg::LTR_E, nlss_pkg::LTR_I,
                     nlss_pkg::LTR_K))) begin
      cut = 3'd4;
    end else if (len_a > LEN_W'(7) &&
                 (e5(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_L, nlss_pkg::LTR_S,
                     nlss_pkg::LTR_E, nlss_pkg::LTR_R) ||
                  e5(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_L, nlss_pkg::LTR_S,
                     nlss_pkg::LTR_E, nlss_pkg::LTR_N))) begin
      cut = 3'd5;
    end else if (len_a > LEN_W'(6) &&
                 ((bm && e4(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_N, nlss_pkg::LTR_D,
                            nlss_pkg::LTR_E)) ||
                  (nn && e4(sw, nlss_pkg::LTR_A, nlss_pkg::LTR_N, nlss_pkg::LTR_D,
                            nlss_pkg::LTR_E)) ||
                  e4(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_L, nlss_pkg::LTR_S,
                     nlss_pkg::LTR_E) ||
                  (bm && e4(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_S, nlss_pkg::LTR_T,
                            nlss_pkg::LTR_E)) ||
                  (nn && e4(sw, nlss_pkg::LTR_A, nlss_pkg::LTR_S, nlss_pkg::LTR_T,
                            nlss_pkg::LTR_E)) ||
                  (bm && e4(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_R, nlss_pkg::LTR_E,
                            nlss_pkg::LTR_N)) ||
                  (nn && e4(sw, nlss_pkg::LTR_A, nlss_pkg::LTR_R, nlss_pkg::LTR_E,
                            nlss_pkg::LTR_N)))) begin
      cut = 3'd4;
    end else if (len_a > LEN_W'(5) &&
                 ((bm && e3(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_R, nlss_pkg::LTR_E)) ||
                  (nn && e3(sw, nlss_pkg::LTR_A, nlss_pkg::LTR_R, nlss_pkg::LTR_E)) ||
                  (bm && e3(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_S, nlss_pkg::LTR_T)) ||
                  (nn && e3(sw, nlss_pkg::LTR_A, nlss_pkg::LTR_S, nlss_pkg::LTR_T)) ||
                  e3(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_N, nlss_pkg::LTR_E) ||
                  (nn && e3(sw, nlss_pkg::LTR_A, nlss_pkg::LTR_N, nlss_pkg::LTR_E)))) begin
      cut = 3'd3;
    end else if (len_a > LEN_W'(4) &&
                 (e2(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_R) ||
                  e2(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_N) ||
                  e2(sw, nlss_pkg::LTR_E, nlss_pkg::LTR_T) ||
                  (nn && e2(sw, nlss_pkg::LTR_A, nlss_pkg::LTR_R)) ||
                  (bm && e2(sw, nlss_pkg::LTR_S, nlss_pkg::LTR_T)) ||
                  e2(sw, nlss_pkg::LTR_T, nlss_pkg::LTR_E))) begin
      cut = 3'd2;
    end else if (len_a > LEN_W'(3) &&
                 (sw[0][nlss_pkg::LTR_A] || sw[0][nlss_pkg::LTR_E] ||
                  sw[0][nlss_pkg::LTR_N])) begin
      cut = 3'd1;
    end else begin
      cut = 3'd0;
    end

    res   = len_a - LEN_W'(cut);
    res_x = XW'(res);
    stem  = (res_x > XW'(255)) ? 8'hFF : res_x[7:0];
  end

endmodule

/* sv/norwegian_light_suffix_stemmer.sv */
// norwegian_light_suffix_stemmer: top level; seven-cell character window,
// length counter, rule logic and output register.
// Depends on nlss_pkg, nlss_cell and nlss_rules.

// One character is transferred per clock cycle, back to back, as long as the
// output register is empty or being drained. The stem length of a word is
// offered by the output register in the cycle after the transfer of its last
// character (tlast high); the rules are evaluated on the characters entering
// the seven cells in the cycle of that transfer. Characters without tlast
// give no result. Words longer than MAX_WORD_LEN keep the saturated count and
// raise too_long. The language register bits are sampled on the transfer of
// the last character and should only be written between words.

module norwegian_light_suffix_stemmer #(
  parameter int MAX_WORD_LEN = 255,
  parameter int CHAR_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // char_code[15:0]
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // stem_length[7:0]
  output logic        out_tuser,  // too_long
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [0:0]  cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int WIN   = nlss_pkg::WIN;

  logic                 bm_r;
  logic                 nn_r;
  logic [LEN_W-1:0]     cnt_r;
  logic [LEN_W-1:0]     cnt_nxt;
  logic                 ovf_r;
  logic                 ovf_nxt;
  logic                 out_valid_r;
  logic [7:0]           out_stem_r;
  logic                 out_long_r;
  logic                 in_xfer;
  logic [CHAR_BITS-1:0] ch;
  logic [CHAR_BITS-1:0] chain [WIN];
  nlss_pkg::win_t       win;
  nlss_pkg::cell_ctl_t  ctl;
  logic [7:0]           stem;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign ch        = CHAR_BITS'(in_tdata);
  assign ctl.shift = in_xfer;
  assign ctl.clr   = in_tlast;

  for (genvar i = 0; i < WIN; i++) begin : g_cell
    nlss_cell #(.CHAR_BITS(CHAR_BITS)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .din   ((i == 0) ? ch : chain[(i == 0) ? 0 : i-1]),
      .dout  (chain[i]),
      .flags (win[i])
    );
  end

  always_comb begin
    if (cnt_r >= LEN_W'(MAX_WORD_LEN)) begin
      cnt_nxt = LEN_W'(MAX_WORD_LEN);
      ovf_nxt = 1'b1;
    end else begin
      cnt_nxt = cnt_r + LEN_W'(1);
      ovf_nxt = ovf_r;
    end
  end

  nlss_rules #(.LEN_W(LEN_W)) u_rules (
    .win  (win),
    .len  (cnt_nxt),
    .bm   (bm_r),
    .nn   (nn_r),
    .stem (stem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_r        <= 1'b1;
      nn_r        <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          nlss_pkg::REG_USE_BOKMAAL: bm_r <= cfg_wdata[0];
          nlss_pkg::REG_USE_NYNORSK: nn_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        cnt_r <= in_tlast ? '0 : cnt_nxt;
        ovf_r <= in_tlast ? 1'b0 : ovf_nxt;
      end
      if (in_xfer && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_tlast) begin
      out_stem_r <= stem;
      out_long_r <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_stem_r;
  assign out_tuser  = out_long_r;

endmodule

/* sv/nlss_checker.sv */
// nlss_checker: port-level assertions for the stemmer, bound to the top level.
// Depends on norwegian_light_suffix_stemmer.

module nlss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser,
  input logic        cfg_we,
  input logic [0:0]  cfg_addr,
  input logic [0:0]  cfg_wdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after last character");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready && in_tlast) |=> !out_tvalid)
    else $error("result without last character");

  a_stem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 8'd0)
    else $error("empty stem");

endmodule

bind norwegian_light_suffix_stemmer nlss_checker u_nlss_checker (.*);

/* verif/norwegian_light_suffix_stemmer_tb.sv */
// norwegian_light_suffix_stemmer_tb: self-checking testbench for the norwegian light
// suffix stemmer; streams words one character per transfer and checks each stem length
// against a built-in rule predictor. Depends on nlss_pkg and norwegian_light_suffix_stemmer.

module norwegian_light_suffix_stemmer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN     = 255;
  localparam int SETTLE      = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_ENDINGS   = 37;

  typedef struct packed {
    logic [7:0] stem_len;
    logic       too_long;
  } stem_res_t;

  typedef logic [15:0] chars_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [0:0]  cfg_wdata = '0;

  norwegian_light_suffix_stemmer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] tail_q [nlss_pkg::WIN];
  int          word_len;
  bit          word_ovf;
  bit          lang_bm;
  bit          lang_nn;
  stem_res_t   stem_q[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int chars_sent;
  int err_cnt;
  int cycles;

  string endings [N_ENDINGS] = '{
    "heter", "heten", "heita", "heiter", "leiken", "leikar", "dom", "het", "heit",
    "semd", "leik", "elser", "elsen", "ende", "ande", "else", "este", "aste",
    "eren", "aren", "ere", "are", "est", "ast", "ene", "ane", "er", "en", "et",
    "ar", "st", "te", "a", "e", "n", "s", ""
  };
  string letters = "adehiklmnorst";

  function automatic bit tail_is(string suf, int off);
    int n;
    n = suf.len();
    for (int i = 0; i < n; i++) begin
      if (off + i >= nlss_pkg::WIN) return 1'b0;
      if (tail_q[off+i] != 16'(suf[n-1-i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int stem_of();
    int len;
    int off;
    bit bm;
    bit nn;
    logic [15:0] c;
    len = word_len;
    off = 0;
    bm  = lang_bm;
    nn  = lang_nn;
    if (len > 4 && tail_q[0] == 16'(nlss_pkg::CH_S)) begin
      len--;
      off = 1;
    end
    if (len > 7 && ((bm && tail_is("heter", off)) || (bm && tail_is("heten", off)) ||
                    (nn && tail_is("heita", off))))
      return len - 5;
    if (len > 8 && nn && (tail_is("heiter", off) || tail_is("leiken", off) ||
                          tail_is("leikar", off)))
      return len - 6;
    if (len > 5 && (tail_is("dom", off) || (bm && tail_is("het", off))))
      return len - 3;
    if (len > 6 && nn && (tail_is("heit", off) || tail_is("semd", off) ||
                          tail_is("leik", off)))
      return len - 4;
    if (len > 7 && (tail_is("elser", off) || tail_is("elsen", off)))
      return len - 5;
    if (len > 6 && ((bm && tail_is("ende", off)) || (nn && tail_is("ande", off)) ||
                    tail_is("else", off) || (bm && tail_is("este", off)) ||
                    (nn && tail_is("aste", off)) || (bm && tail_is("eren", off)) ||
                    (nn && tail_is("aren", off))))
      return len - 4;
    if (len > 5 && ((bm && tail_is("ere", off)) || (nn && tail_is("are", off)) ||
                    (bm && tail_is("est", off)) || (nn && tail_is("ast", off)) ||
                    tail_is("ene", off) || (nn && tail_is("ane", off))))
      return len - 3;
    if (len > 4 && (tail_is("er", off) || tail_is("en", off) || tail_is("et", off) ||
                    (nn && tail_is("ar", off)) || (bm && tail_is("st", off)) ||
                    tail_is("te", off)))
      return len - 2;
    if (len > 3) begin
      c = tail_q[off];
      if (c == 16'(nlss_pkg::CH_A) || c == 16'(nlss_pkg::CH_E) ||
          c == 16'(nlss_pkg::CH_N)) return len - 1;
    end
    return len;
  endfunction

  function automatic void clear_word();
    foreach (tail_q[i]) tail_q[i] = '0;
    word_len = 0;
    word_ovf = 1'b0;
  endfunction

  function automatic void predict_char(logic [15:0] c, logic last);
    int s;
    stem_res_t r;
    for (int i = nlss_pkg::WIN - 1; i > 0; i--) tail_q[i] = tail_q[i-1];
    tail_q[0] = c;
    if (word_len >= MAX_LEN) begin
      word_len = MAX_LEN;
      word_ovf = 1'b1;
    end else begin
      word_len++;
    end
    if (last) begin
      s = stem_of();
      if (s > 255) s = 255;
      r.stem_len = 8'(s);
      r.too_long = word_ovf;
      stem_q.push_back(r);
      clear_word();
    end
  endfunction

  task automatic send_char(input logic [15:0] c, input logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_char(c, last);
    chars_sent++;
  endtask

  task automatic send_word(input chars_t w);
    foreach (w[i]) send_char(w[i], i == w.size() - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (stem_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_lang(input bit bm, input bit nn);
    cfg_we    <= 1'b1;
    cfg_addr  <= nlss_pkg::REG_USE_BOKMAAL;
    cfg_wdata <= bm;
    @(posedge clk);
    cfg_addr  <= nlss_pkg::REG_USE_NYNORSK;
    cfg_wdata <= nn;
    @(posedge clk);
    cfg_we <= 1'b0;
    lang_bm = bm;
    lang_nn = nn;
  endtask

  function automatic chars_t text(string s);
    chars_t w;
    for (int i = 0; i < s.len(); i++) w.push_back(16'(s[i]));
    return w;
  endfunction

  function automatic logic [15:0] rand_char();
    int pick;
    logic [7:0] ltr;
    pick = $urandom_range(99);
    ltr  = 8'(letters[$urandom_range(letters.len() - 1)]);
    if (pick < 70) return {8'h00, ltr};
    if (pick < 85) return {8'($urandom_range(255, 1)), ltr};
    return 16'($urandom);
  endfunction

  function automatic chars_t make_word();
    chars_t w;
    chars_t tl;
    int pick;
    int plen;
    pick = $urandom_range(99);
    plen = (pick == 0) ? $urandom_range(300, 245) : $urandom_range(6, 0);
    for (int i = 0; i < plen; i++) w.push_back(rand_char());
    if (pick >= 90) begin
      for (int i = $urandom_range(3, 1); i > 0; i--) w.push_back(16'($urandom));
    end else begin
      tl = text(endings[$urandom_range(N_ENDINGS - 1)]);
      foreach (tl[i]) w.push_back(tl[i]);
      if ($urandom_range(3) == 0) w.push_back(16'(nlss_pkg::CH_S));
    end
    if (w.size() == 0) w.push_back(rand_char());
    return w;
  endfunction

  // result side: check each transfer, then decide the next ready
  always @(posedge clk) begin : result_check
    stem_res_t want;
    stem_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.stem_len = out_tdata;
      got.too_long = out_tuser;
      if (stem_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: stem_length %0d too_long %0b", got.stem_len,
                   got.too_long);
      end else begin
        want = stem_q.pop_front();
        if (got.stem_len !== want.stem_len || got.too_long !== want.too_long) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: stem_length exp %0d got %0d, too_long exp %0b got %0b",
                     want.stem_len, got.stem_len, want.too_long, got.too_long);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed();
    chars_t w;
    send_word('{16'hFFFF});
    send_word('{16'h0000});
    send_word(text("bilens"));
    send_word(text("ande"));
    send_word(text("lesen"));
    send_word(text("ta"));
    w = text("bile");
    w.push_back(16'h8065);
    send_word(w);
    drain();
  endtask

  task automatic test_saturation();
    chars_t w;
    for (int i = 0; i < MAX_LEN - 5; i++) w.push_back(rand_char());
    send_word({w, text("heter")});
    send_word({w, text("xelsens")});
    drain();
  endtask

  task automatic test_random();
    bit bm_set [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    bit nn_set [6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    int goal;
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 8;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      set_lang(bm_set[seg], nn_set[seg]);
      goal = chars_sent + 130;
      while (chars_sent < goal) send_word(make_word());
      drain();
    end
  endtask

  initial begin
    clear_word();
    lang_bm     = 1'b1;
    lang_nn     = 1'b0;
    tx_idle_pct = 8;
    rx_idle_pct = 65;
    chars_sent  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_saturation();
    test_random();
    if (err_cnt == 0 && stem_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
sv/nlss_pkg.sv
sv/nlss_cell.sv
sv/nlss_rules.sv
sv/norwegian_light_suffix_stemmer.sv
sv/nlss_checker.sv
verif/norwegian_light_suffix_stemmer_tb.sv
